### src/rpn_pkg.sv
// Shared types and constants of the RPN stack calculator.
package rpn_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned BIT_W    = $clog2(DATA_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DATA_W - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_RUN,
        S_DONE,
        S_EMIT
    } t_state;

endpackage

### src/rpn_if.sv
// Valid/ready channel interfaces for commands and results.
interface rpn_in_if
    import rpn_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [DATA_W-1:0]  operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface rpn_out_if
    import rpn_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  top_value;
    logic [COUNT_W-1:0]        stack_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_count, input status,
                    output ready);
endinterface

### src/rpn_stack_calculator.sv
// Push, unknown command, underflow and overflow items go from S_EXEC straight to S_EMIT;
// divide by zero goes S_EXEC, S_LOAD, S_EMIT. Add, subtract, multiply and divide go
// S_EXEC, S_LOAD, S_RUN, S_DONE, S_EMIT, with S_RUN as the 32-step bit-serial unit (serial
// adder, shift-add multiplier, restoring divider). One item at a time: the next is accepted
// only back in S_IDLE, later while a finished result still waits in the output register.
// Reset (synchronous, active low) empties the stack; the entry memory is not cleared.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_in_if.sink     i_in,
    rpn_out_if.source  o_out
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;

    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_top;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_val;
    t_status           r_status;

    logic [DATA_W-1:0] r_x, r_y, r_acc, r_rem;
    logic              r_carry;
    logic              r_neg;
    logic [BIT_W-1:0]  r_bit;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_otop;
    logic [COUNT_W-1:0] r_ocount;
    t_status           r_ostatus;

    logic              w_accept;
    logic              w_full;
    logic              w_under;
    logic              w_known;
    logic              w_divzero;
    logic              w_emit;
    logic [AW-1:0]     w_push_addr;
    logic [AW-1:0]     w_next_addr;
    logic              w_sum_bit;
    logic              w_carry;
    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_result;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign w_accept    = i_in.valid & i_in.ready;
    assign w_full      = (r_count >= CW'(STACK_DEPTH));
    assign w_under     = (r_count < CW'(2));
    assign w_known     = (r_cmd == CMD_ADD) || (r_cmd == CMD_SUB) ||
                         (r_cmd == CMD_MUL) || (r_cmd == CMD_DIV);
    assign w_divzero   = (r_cmd == CMD_DIV) && (r_rd == '0);
    assign w_emit      = !r_ovalid || o_out.ready;
    assign w_push_addr = r_count[AW-1:0];
    assign w_next_addr = AW'(r_count - CW'(2));

    // Serial adder bit and restoring divider step
    assign w_sum_bit = r_x[0] ^ r_y[0] ^ r_carry;
    assign w_carry   = (r_x[0] & r_y[0]) | (r_carry & (r_x[0] ^ r_y[0]));
    assign w_rem_sh  = {r_rem, r_x[DATA_W-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_y};
    assign w_result  = (r_cmd == CMD_DIV) ? (r_neg ? (DATA_W'(0) - r_x) : r_x) : r_acc;
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.top_value   = r_otop;
    assign o_out.stack_count = r_ocount;
    assign o_out.status      = r_ostatus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_PUSH || !w_known || w_under) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = w_divzero ? S_EMIT : S_RUN;
            end
            S_RUN: begin
                if (r_bit == BIT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port at the second entry
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_cmd == CMD_PUSH && !w_full) begin
            r_mem[w_push_addr] <= r_val;
        end else if (r_state == S_DONE) begin
            r_mem[w_next_addr] <= w_result;
        end
        r_rd <= r_mem[w_next_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_EXEC && r_cmd == CMD_PUSH && !w_full) begin
            r_count <= r_count + CW'(1);
        end else if (r_state == S_DONE) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_EMIT && w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_emit) begin
            r_otop    <= (r_count != '0) ? r_top : '0;
            r_ocount  <= w_count_ext[COUNT_W-1:0];
            r_ostatus <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd <= t_cmd'(i_in.command);
                    r_val <= i_in.operand_value;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_PUSH && w_full) begin
                    r_status <= ST_OVER;
                end else if (w_known && w_under) begin
                    r_status <= ST_UNDER;
                end else begin
                    r_status <= ST_OK;
                end
                if (r_cmd == CMD_PUSH && !w_full) begin
                    r_top <= r_val;
                end
            end
            S_LOAD: begin
                // A is the cached top, B the entry read below it
                r_bit   <= '0;
                r_acc   <= '0;
                r_rem   <= '0;
                r_neg   <= r_top[DATA_W-1] ^ r_rd[DATA_W-1];
                if (r_cmd == CMD_SUB) begin
                    r_x     <= r_top;
                    r_y     <= ~r_rd;
                    r_carry <= 1'b1;
                end else if (r_cmd == CMD_DIV) begin
                    if (w_divzero) begin
                        r_status <= ST_DIVZERO;
                    end
                    r_x     <= r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
                    r_y     <= r_rd[DATA_W-1] ? (DATA_W'(0) - r_rd) : r_rd;
                    r_carry <= 1'b0;
                end else begin
                    r_x     <= r_top;
                    r_y     <= r_rd;
                    r_carry <= 1'b0;
                end
            end
            S_RUN: begin
                r_bit <= r_bit + BIT_W'(1);
                if (r_cmd == CMD_MUL) begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= {r_x[DATA_W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[DATA_W-1:1]};
                end else if (r_cmd == CMD_DIV) begin
                    // Restoring step: quotient bits shift into the numerator register
                    if (!w_diff[DATA_W]) begin
                        r_rem <= w_diff[DATA_W-1:0];
                        r_x   <= {r_x[DATA_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[DATA_W-1:0];
                        r_x   <= {r_x[DATA_W-2:0], 1'b0};
                    end
                end else begin
                    r_acc   <= {w_sum_bit, r_acc[DATA_W-1:1]};
                    r_carry <= w_carry;
                    r_x     <= {1'b0, r_x[DATA_W-1:1]};
                    r_y     <= {1'b0, r_y[DATA_W-1:1]};
                end
            end
            S_DONE: begin
                r_top <= w_result;
            end
            S_EMIT: begin
                r_bit <= r_bit;
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

endmodule

### sim/rpn_stack_calculator_tb.sv
// Self-checking testbench for the RPN stack calculator: directed and random commands.
`timescale 1ns / 100ps

module rpn_stack_calculator_tb
    import rpn_pkg::*;
;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TAIL_CYCLES   = 80;
    localparam int RESET_CYCLES  = 7;

    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [CMD_W-1:0]  CMD_LAST = '1;

    // Idling phases
    localparam logic [1:0] PACE_FULL      = 2'd0;
    localparam logic [1:0] PACE_SEND_IDLE = 2'd1;
    localparam logic [1:0] PACE_RECV_IDLE = 2'd2;
    localparam logic [1:0] PACE_BOTH_IDLE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] operand;
        logic [1:0]        pace;
        logic              hold_for_drain;
    } t_calc_item;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_calc_result;

    logic i_clk;
    logic i_rst_n;

    rpn_in_if  in_ch ();
    rpn_out_if out_ch ();

    rpn_stack_calculator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_calc_item   command_queue [$];
    t_calc_result pending_results [$];

    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    int                calc_depth;
    int                mismatch_count;
    int                idle_cycles;
    logic [1:0]        cur_pace;

    function automatic int send_idle_pct(input logic [1:0] pace);
        return (pace == PACE_SEND_IDLE) ? 83 : (pace == PACE_BOTH_IDLE) ? 16 : 0;
    endfunction

    function automatic int recv_stall_pct(input logic [1:0] pace);
        return (pace == PACE_RECV_IDLE) ? 83 : (pace == PACE_BOTH_IDLE) ? 16 : 0;
    endfunction

    // Apply one command to the shadow stack and return the result it should produce.
    function automatic t_calc_result apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [DATA_W-1:0] operand);
        t_calc_result      res;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] a_mag;
        logic [DATA_W-1:0] b_mag;
        logic [DATA_W-1:0] quot;
        res.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (calc_depth >= STACK_DEPTH) begin
                res.status = ST_OVER;
            end else begin
                calc_stack[calc_depth] = operand;
                calc_depth++;
            end
        end else if (cmd >= CMD_ADD && cmd <= CMD_DIV) begin
            if (calc_depth < 2) begin
                res.status = ST_UNDER;
            end else begin
                a = calc_stack[calc_depth-1];
                b = calc_stack[calc_depth-2];
                r = '0;
                unique case (cmd)
                    CMD_ADD: r = a + b;
                    CMD_SUB: r = a - b;
                    CMD_MUL: r = a * b;
                    default: begin
                        if (b == '0) begin
                            res.status = ST_DIVZERO;
                        end else begin
                            // Truncate toward zero on magnitudes; MIN / -1 wraps to MIN.
                            a_mag = a[DATA_W-1] ? -a : a;
                            b_mag = b[DATA_W-1] ? -b : b;
                            quot  = a_mag / b_mag;
                            r     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
                        end
                    end
                endcase
                if (res.status == ST_OK) begin
                    calc_depth--;
                    calc_stack[calc_depth-1] = r;
                end
            end
        end
        res.top   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        res.count = COUNT_W'(calc_depth);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_MIN;
            2:       return DATA_MAX;
            3:       return '1;
            4:       return DATA_W'(1);
            5, 6:    return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] operand,
                              input logic [1:0] pace, input logic hold);
        t_calc_item it;
        it.cmd            = cmd;
        it.operand        = operand;
        it.pace           = pace;
        it.hold_for_drain = hold;
        command_queue.push_back(it);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Command driver
    always @(posedge i_clk) begin
        t_calc_item   nxt;
        t_calc_result res;
        logic         vld_next;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            vld_next = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                res = apply_command(in_ch.command, in_ch.operand_value);
                pending_results.push_back(res);
                vld_next = 1'b0;
            end
            if (!vld_next && command_queue.size() > 0) begin
                nxt = command_queue[0];
                // Hold a marked item until every outstanding result has drained.
                if (!(nxt.hold_for_drain && pending_results.size() != 0) &&
                    $urandom_range(0, 99) >= send_idle_pct(nxt.pace)) begin
                    void'(command_queue.pop_front());
                    in_ch.command       <= nxt.cmd;
                    in_ch.operand_value <= nxt.operand;
                    cur_pace            <= nxt.pace;
                    vld_next = 1'b1;
                end
            end
            in_ch.valid <= vld_next;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_calc_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result top=%h count=%0d status=%0d",
                                              out_ch.top_value, out_ch.stack_count,
                                              out_ch.status));
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.top_value !== want.top)
                        report_mismatch($sformatf("top_value %h, want %h",
                                                  out_ch.top_value, want.top));
                    if (out_ch.stack_count !== want.count)
                        report_mismatch($sformatf("stack_count %0d, want %0d",
                                                  out_ch.stack_count, want.count));
                    if (out_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_ch.status, want.status));
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct(cur_pace));
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[rpn_stack_calculator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         push_bias;
        int         roll;
        logic [CMD_W-1:0] cmd;
        logic [1:0] pace;

        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_PUSH;
        in_ch.operand_value = '0;
        out_ch.ready        = 1'b0;
        cur_pace            = PACE_FULL;
        calc_depth          = 0;
        mismatch_count      = 0;
        idle_cycles         = 0;
        push_bias           = 50;

        // Directed: underflow on empty, divide by zero, MIN / -1, unknown, overflow.
        queue_item(CMD_ADD,  '0,          PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, '0,          PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, DATA_W'(7),  PACE_FULL, 1'b0);
        queue_item(CMD_DIV,  '1,          PACE_FULL, 1'b0);
        queue_item(CMD_SUB,  DATA_MAX,    PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, '1,          PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, DATA_MIN,    PACE_FULL, 1'b0);
        queue_item(CMD_DIV,  DATA_MIN,    PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, DATA_MAX,    PACE_FULL, 1'b0);
        queue_item(CMD_ADD,  '0,          PACE_FULL, 1'b0);
        queue_item(CMD_PUSH, DATA_MAX,    PACE_FULL, 1'b0);
        queue_item(CMD_MUL,  '0,          PACE_FULL, 1'b0);
        queue_item(CMD_LAST, '1,          PACE_FULL, 1'b0);
        // Fill from two entries to full, then push once more.
        for (int k = 0; k < STACK_DEPTH - 1; k++)
            queue_item(CMD_PUSH, pick_operand(), PACE_FULL, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pace = 2'(n * 4 / RANDOM_ITEMS);
            // Shift the push rate now and then so the stack swings between empty and full.
            if (n % 60 == 0)
                push_bias = $urandom_range(30, 75);
            roll = $urandom_range(0, 99);
            if (roll < push_bias)
                cmd = CMD_PUSH;
            else if (roll < 96)
                cmd = CMD_W'($urandom_range(CMD_ADD, CMD_DIV));
            else
                cmd = CMD_W'($urandom_range(CMD_DIV + 1, CMD_LAST));
            queue_item(cmd, pick_operand(), pace, n % (RANDOM_ITEMS / 4) == 0);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample away from the active edge so the driver and monitor have settled.
        do @(negedge i_clk);
        while (command_queue.size() != 0 || in_ch.valid || pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("[rpn_stack_calculator] OK");
        else
            $display("[rpn_stack_calculator] ERROR");
        $finish;
    end

endmodule
